// ----- rtl/core/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes of the sorted task queue
// Field widths, opcodes, status codes and the structs that run along the
// cell chain.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int ID_W    = 4;
  localparam int OPC_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;
  localparam int NUM_IDS = 1 << ID_W;

  localparam logic [OPC_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OPC_W-1:0] OP_DELETE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_DUP    = 2'd3;

  // one queue slot
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
  } ent_t;

  // operation token walking down the chain
  typedef struct packed {
    logic            vld;  // token present at this cell
    logic            ins;  // 1 insert, 0 remove
    logic            hit;  // insert placed / remove target found
    logic            cv;   // insert still carries an entry
    logic [ID_W-1:0] id;   // carried id (insert) or target id (remove)
  } tok_t;

endpackage

// ----- rtl/core/stq_if.sv -----
// ----------------------------------------------------------------------------
// stq_if: channel interfaces of the sorted task queue
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  task_id;
  logic [31:0] sort_key;

  modport source (output valid, opcode, task_id, sort_key, input ready);
  modport sink   (input valid, opcode, task_id, sort_key, output ready);
endinterface

interface stq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] extracted_task;
  logic       extracted_valid;
  logic [3:0] head_task;
  logic       head_valid;
  logic [4:0] entry_count;

  modport source (output valid, status, extracted_task, extracted_valid,
                  head_task, head_valid, entry_count, input ready);
  modport sink   (input valid, status, extracted_task, extracted_valid,
                  head_task, head_valid, entry_count, output ready);
endinterface

interface stq_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;

  modport source (output valid, order_mode, input ready);
  modport sink   (input valid, order_mode, output ready);
endinterface

// ----- rtl/core/stq_cell.sv -----
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted task queue
// Holds one entry and acts on the token passing by: an insert drops its
// carried entry here and carries the old one on; a remove pulls the right
// neighbor's entry in once the target has been seen.
// ----------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
#(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mode,
  input  tok_t                 tok_in,
  input  logic [KEY_WIDTH-1:0] tkey_in,
  output tok_t                 tok_out,
  output logic [KEY_WIDTH-1:0] tkey_out,
  input  ent_t                 nbr_ent,
  input  logic [KEY_WIDTH-1:0] nbr_key,
  output ent_t                 ent,
  output logic [KEY_WIDTH-1:0] ent_key
);

  ent_t                 ent_r, ent_nxt;
  logic [KEY_WIDTH-1:0] ekey_r, ekey_nxt;
  tok_t                 tok_r, tok_nxt;
  logic [KEY_WIDTH-1:0] tkey_r, tkey_nxt;
  logic                 goes_before;
  logic                 place;

  assign goes_before = mode ? (tkey_in < ekey_r) : (tkey_in > ekey_r);
  assign place = tok_in.cv && (tok_in.hit || !ent_r.vld || goes_before);

  always_comb begin
    ent_nxt  = ent_r;
    ekey_nxt = ekey_r;
    tok_nxt  = tok_in;
    tkey_nxt = tkey_in;
    if (tok_in.vld) begin
      if (tok_in.ins) begin
        if (place) begin
          // take the carried entry, pass the displaced one on
          ent_nxt.vld = 1'b1;
          ent_nxt.id  = tok_in.id;
          ekey_nxt    = tkey_in;
          tok_nxt.hit = 1'b1;
          tok_nxt.cv  = ent_r.vld;
          tok_nxt.id  = ent_r.id;
          tkey_nxt    = ekey_r;
        end
      end else if (tok_in.hit || (ent_r.vld && ent_r.id == tok_in.id)) begin
        // close the gap: shift the right neighbor up
        ent_nxt     = nbr_ent;
        ekey_nxt    = nbr_key;
        tok_nxt.hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      tok_r <= '0;
    end else begin
      ent_r <= ent_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ekey_r <= ekey_nxt;
    tkey_r <= tkey_nxt;
  end

  assign tok_out  = tok_r;
  assign tkey_out = tkey_r;
  assign ent      = ent_r;
  assign ent_key  = ekey_r;

endmodule

// ----- rtl/core/sorted_task_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_task_queue: ordered task queue for a scheduler
// Insert, extract-head and delete on a sorted list of task ids with keys.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request (opcode, task_id, sort_key); in_ch.ready is
//          high while no request is in progress.
//   out_ch returns one result per request: status, extracted task, head
//          and entry count after the request.
//   cfg_ch writes order_mode (0 key descending, 1 key ascending); always
//          ready, write it only while the queue is idle.
// Walk: a request that changes the list sends a token down the chain of
//   MAX_TASKS cells, one cell per cycle; a refused request or an unused
//   opcode goes straight to the result state. One request is in progress
//   at a time.
// Reset: rst_n clears the list, the membership flags, the count and the
//   mode. No clearing pass is needed.
// Stall: a result waits in the output register while out_ch.ready is low;
//   the next request is accepted meanwhile, and its result waits until the
//   output register frees up.
// ----------------------------------------------------------------------------
module sorted_task_queue
  import stq_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int KEY_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch,
  stq_cfg_if.sink   cfg_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic                   mode_r;
  logic [NUM_IDS-1:0]     flags_r, flags_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [STAT_W-1:0]      res_status_r, res_status_nxt;
  logic [ID_W-1:0]        res_ext_id_r, res_ext_id_nxt;
  logic                   res_ext_vld_r, res_ext_vld_nxt;

  logic                   out_vld_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [ID_W-1:0]        out_ext_id_r;
  logic                   out_ext_vld_r;
  logic [ID_W-1:0]        out_head_r;
  logic                   out_head_vld_r;
  logic [CNT_W-1:0]       out_cnt_r;

  tok_t                   tok_c  [MAX_TASKS+1];
  logic [KEY_WIDTH-1:0]   tkey_c [MAX_TASKS+1];
  ent_t                   ent_c  [MAX_TASKS+1];
  logic [KEY_WIDTH-1:0]   ekey_c [MAX_TASKS+1];

  logic                   accept;
  logic                   in_range;
  logic                   is_member;
  logic                   out_load;
  tok_t                   launch;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_range     = 32'(in_ch.task_id) < 32'(MAX_TASKS);
  assign is_member    = flags_r[in_ch.task_id];
  assign out_load     = (state_r == S_DONE) && (!out_vld_r || out_ch.ready);

  // decode the request against the membership flags and the head slot
  always_comb begin
    flags_nxt       = flags_r;
    cnt_nxt         = cnt_r;
    res_status_nxt  = res_status_r;
    res_ext_id_nxt  = res_ext_id_r;
    res_ext_vld_nxt = res_ext_vld_r;
    launch          = '0;
    if (accept) begin
      res_status_nxt  = ST_OK;
      res_ext_id_nxt  = '0;
      res_ext_vld_nxt = 1'b0;
      unique case (in_ch.opcode)
        OP_INSERT: begin
          if (in_range && !is_member) begin
            launch.vld = 1'b1;
            launch.ins = 1'b1;
            launch.cv  = 1'b1;
            launch.id  = in_ch.task_id;
            flags_nxt[in_ch.task_id] = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            res_status_nxt = ST_DUP;
          end
        end
        OP_EXTRACT: begin
          if (ent_c[0].vld) begin
            launch.vld      = 1'b1;
            launch.id       = ent_c[0].id;
            res_ext_id_nxt  = ent_c[0].id;
            res_ext_vld_nxt = 1'b1;
            flags_nxt[ent_c[0].id] = 1'b0;
            cnt_nxt = cnt_r - CNT_W'(1);
          end else begin
            res_status_nxt = ST_EMPTY;
          end
        end
        OP_DELETE: begin
          if (in_range && is_member) begin
            launch.vld = 1'b1;
            launch.id  = in_ch.task_id;
            flags_nxt[in_ch.task_id] = 1'b0;
            cnt_nxt = cnt_r - CNT_W'(1);
          end else begin
            res_status_nxt = ST_ABSENT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tok_c[0]          = launch;
  assign tkey_c[0]         = KEY_WIDTH'(in_ch.sort_key);
  assign ent_c[MAX_TASKS]  = '0;
  assign ekey_c[MAX_TASKS] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    stq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .mode     (mode_r),
      .tok_in   (tok_c[i]),
      .tkey_in  (tkey_c[i]),
      .tok_out  (tok_c[i+1]),
      .tkey_out (tkey_c[i+1]),
      .nbr_ent  (ent_c[i+1]),
      .nbr_key  (ekey_c[i+1]),
      .ent      (ent_c[i]),
      .ent_key  (ekey_c[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = launch.vld ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (tok_c[MAX_TASKS].vld) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= 1'b0;
      flags_r   <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.order_mode;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r  <= res_status_nxt;
    res_ext_id_r  <= res_ext_id_nxt;
    res_ext_vld_r <= res_ext_vld_nxt;
    if (out_load) begin
      out_status_r   <= res_status_r;
      out_ext_id_r   <= res_ext_id_r;
      out_ext_vld_r  <= res_ext_vld_r;
      out_head_r     <= ent_c[0].vld ? ent_c[0].id : '0;
      out_head_vld_r <= ent_c[0].vld;
      out_cnt_r      <= cnt_r;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.extracted_task  = out_ext_id_r;
  assign out_ch.extracted_valid = out_ext_vld_r;
  assign out_ch.head_task       = out_head_r;
  assign out_ch.head_valid      = out_head_vld_r;
  assign out_ch.entry_count     = out_cnt_r;

`ifndef SYNTHESIS
  a_cnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == $countones(flags_r))
    else $error("entry count disagrees with membership flags");

  a_head_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (ent_c[0].vld == (cnt_r != '0)))
    else $error("head slot disagrees with entry count");

  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_head_vld_r == (out_cnt_r != '0)))
    else $error("head_valid disagrees with entry_count");

  a_ext_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ext_vld_r) |-> (out_status_r == ST_OK))
    else $error("extracted task with error status");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    tok_c[MAX_TASKS].vld |-> (state_r == S_WALK))
    else $error("token left the chain outside a walk");
`endif

endmodule

// ----- sim/sorted_task_queue_test.sv -----
// ----------------------------------------------------------------------------
// sorted_task_queue_test: self-checking bench for the sorted task queue
// A short table of directed requests (empty extract, absent delete, double
// insert, unused opcode, key extremes, ties), then about 800 random requests
// over several order-mode settings. Mostly well-formed traffic is used, with
// some noise mixed in. A local model of the list predicts each untyped result.
// The request side sends in bursts and the result side stalls at random.
// ----------------------------------------------------------------------------
module sorted_task_queue_test;
  import stq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [ID_W-1:0]  task_id;
    logic [31:0]      sort_key;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   extracted_task;
    logic              extracted_valid;
    logic [ID_W-1:0]   head_task;
    logic              head_valid;
    logic [CNT_W-1:0]  entry_count;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     typed;   // use res below instead of the model
    result_t  res;
  } table_row_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic [31:0]     key;
  } queued_task_t;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int N_ROWS   = 18;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 130;
  localparam int HOLD_CYCLES = 400;

  localparam result_t NO_CHECK = '0;

  localparam table_row_t DIRECTED [N_ROWS] = '{
    '{'{OP_EXTRACT, 4'd0,  32'd0},        1'b1, '{ST_EMPTY,  4'd0, 1'b0, 4'd0,  1'b0, 5'd0}},
    '{'{OP_DELETE,  4'd5,  32'd0},        1'b1, '{ST_ABSENT, 4'd0, 1'b0, 4'd0,  1'b0, 5'd0}},
    '{'{OP_UNUSED,  4'd15, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,     4'd0, 1'b0, 4'd0,  1'b0, 5'd0}},
    '{'{OP_INSERT,  4'd0,  32'd0},        1'b1, '{ST_OK,     4'd0, 1'b0, 4'd0,  1'b1, 5'd1}},
    '{'{OP_INSERT,  4'd0,  32'd7},        1'b1, '{ST_DUP,    4'd0, 1'b0, 4'd0,  1'b1, 5'd1}},
    '{'{OP_INSERT,  4'd15, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,     4'd0, 1'b0, 4'd15, 1'b1, 5'd2}},
    '{'{OP_INSERT,  4'd3,  32'd5},        1'b0, NO_CHECK},
    '{'{OP_INSERT,  4'd4,  32'd5},        1'b0, NO_CHECK},
    '{'{OP_INSERT,  4'd7,  32'd5},        1'b0, NO_CHECK},
    '{'{OP_INSERT,  4'd9,  32'h8000_0000}, 1'b0, NO_CHECK},
    '{'{OP_INSERT,  4'd10, 32'h5555_5555}, 1'b0, NO_CHECK},
    '{'{OP_INSERT,  4'd5,  32'hAAAA_AAAA}, 1'b0, NO_CHECK},
    '{'{OP_DELETE,  4'd4,  32'd0},        1'b0, NO_CHECK},
    '{'{OP_DELETE,  4'd0,  32'd0},        1'b0, NO_CHECK},
    '{'{OP_EXTRACT, 4'd0,  32'd0},        1'b1, '{ST_OK,     4'd15, 1'b1, 4'd5, 1'b1, 5'd5}},
    '{'{OP_UNUSED,  4'd0,  32'd0},        1'b0, NO_CHECK},
    '{'{OP_DELETE,  4'd15, 32'd0},        1'b1, '{ST_ABSENT, 4'd0, 1'b0, 4'd5,  1'b1, 5'd5}},
    '{'{OP_EXTRACT, 4'd0,  32'd0},        1'b0, NO_CHECK}
  };

  logic clk;
  logic rst_n;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();
  stq_cfg_if cfg_ch ();

  sorted_task_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the list, in queue order
  queued_task_t run_list[$];
  logic         queued[NUM_IDS];
  logic         ascending;

  result_t pending_results[$];
  int      fail_cnt;
  int      requests_sent;
  int      results_seen;
  int      deepest_fill;
  int      mode_writes;
  bit      long_hold_req;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("sorted_task_queue_test: FAIL");
    $finish;
  end

  function automatic bit key_ahead(input logic [31:0] new_key, input logic [31:0] old_key);
    return ascending ? (new_key < old_key) : (new_key > old_key);
  endfunction

  function automatic result_t apply_request(input request_t r);
    result_t res;
    int      pos;
    res = '0;
    case (r.opcode)
      OP_INSERT: begin
        if (queued[r.task_id]) begin
          res.status = ST_DUP;
        end else begin
          // land behind every entry with an equal key
          pos = 0;
          while (pos < run_list.size() && !key_ahead(r.sort_key, run_list[pos].key))
            pos++;
          run_list.insert(pos, '{r.task_id, r.sort_key});
          queued[r.task_id] = 1'b1;
        end
      end
      OP_EXTRACT: begin
        if (run_list.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.extracted_task  = run_list[0].id;
          res.extracted_valid = 1'b1;
          queued[run_list[0].id] = 1'b0;
          void'(run_list.pop_front());
        end
      end
      OP_DELETE: begin
        if (!queued[r.task_id]) begin
          res.status = ST_ABSENT;
        end else begin
          pos = 0;
          while (run_list[pos].id != r.task_id)
            pos++;
          run_list.delete(pos);
          queued[r.task_id] = 1'b0;
        end
      end
      default: ;
    endcase
    if (run_list.size() != 0) begin
      res.head_task  = run_list[0].id;
      res.head_valid = 1'b1;
    end
    res.entry_count = CNT_W'(run_list.size());
    if (run_list.size() > deepest_fill)
      deepest_fill = run_list.size();
    return res;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 7));  // dense keys for ties
      default: return $urandom;
    endcase
  endfunction

  // call at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input request_t r, input logic typed, input result_t typed_res);
    result_t predicted;
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= r.opcode;
    in_ch.task_id  <= r.task_id;
    in_ch.sort_key <= r.sort_key;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(r);
    pending_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_order_mode(input logic mode);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.order_mode <= mode;
    do @(posedge clk); while (!cfg_ch.ready);
    ascending = mode;
    mode_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic make_request(input int insert_pct, output request_t r);
    int roll;
    int fill;
    roll = $urandom_range(0, 99);
    fill = run_list.size();
    r.sort_key = pick_key();
    r.task_id  = ID_W'($urandom_range(0, NUM_IDS - 1));
    if (roll < 10) begin
      // noise: any opcode, any id
      r.opcode = OPC_W'($urandom_range(0, 3));
    end else if (fill == 0 || (fill < NUM_IDS && roll < 10 + insert_pct * 90 / 100)) begin
      while (queued[r.task_id])
        r.task_id = ID_W'($urandom_range(0, NUM_IDS - 1));
      r.opcode = OP_INSERT;
    end else if ($urandom_range(0, 1) == 1) begin
      r.opcode = OP_EXTRACT;
    end else begin
      r.task_id = run_list[$urandom_range(0, fill - 1)].id;
      r.opcode  = OP_DELETE;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.extracted_task, out_ch.extracted_valid,
              out_ch.head_task, out_ch.head_valid, out_ch.entry_count};
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", got.status);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",          want.status,          got.status);
        check_field("extracted_task",  want.extracted_task,  got.extracted_task);
        check_field("extracted_valid", want.extracted_valid, got.extracted_valid);
        check_field("head_task",       want.head_task,       got.head_task);
        check_field("head_valid",      want.head_valid,      got.head_valid);
        check_field("entry_count",     want.entry_count,     got.entry_count);
        results_seen++;
      end
    end
  end

  // result side: stretches of always-ready, random stalls, solid stalls,
  // and one long hold-off on request
  initial begin
    int style;
    int span;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(4, 40);
        repeat (span) begin
          case (style)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       out_ch.ready <= ($urandom_range(0, 5) != 0);
            default: out_ch.ready <= (span < 10) ? 1'b0 : ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    request_t r;
    int       burst_left;
    int       insert_pct [N_PHASES];
    logic     phase_mode [N_PHASES];

    insert_pct = '{70, 45, 60, 35, 80, 50};
    phase_mode = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_INSERT;
    in_ch.task_id     <= '0;
    in_ch.sort_key    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.order_mode <= 1'b0;
    ascending     = 1'b0;
    long_hold_req = 1'b0;
    fail_cnt      = 0;
    requests_sent = 0;
    results_seen  = 0;
    deepest_fill  = 0;
    mode_writes   = 0;
    for (int i = 0; i < NUM_IDS; i++)
      queued[i] = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].res);
    drain_results();

    // list stays populated across mode changes
    for (int p = 0; p < N_PHASES; p++) begin
      write_order_mode(phase_mode[p]);
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 20)
          long_hold_req = 1'b1;
        make_request(insert_pct[p], r);
        send_request(r, 1'b0, NO_CHECK);
        burst_left--;
        if (burst_left == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = $urandom_range(1, 40);
        end
      end
      drain_results();
    end

    write_order_mode(1'b0);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests, %0d results checked, %0d order-mode writes;",
             requests_sent, results_seen, mode_writes);
    $display("list depth reached %0d of %0d tasks.", deepest_fill, NUM_IDS);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("sorted_task_queue_test: PASS");
    end else begin
      $display("sorted_task_queue_test: FAIL");
    end
    $finish;
  end

endmodule
